FILE: hdl/bcc_pkg.sv
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_TICKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_ENABLE  = 2'd2;

  localparam logic [CountW-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CountW-1:0] WINDOW_RESET   = 16'd300;

  typedef struct packed {
    logic [CountW-1:0] debounce_ticks;
    logic [CountW-1:0] window_ticks;
    logic              double_enable;
  } bcc_cfg_t;

  typedef struct packed {
    logic              prev_level;
    logic              edge_armed;
    logic              db_run;
    logic [CountW-1:0] db_rem;
    logic              win_run;
    logic [CountW-1:0] win_rem;
    logic              pending;
  } bcc_state_t;

  localparam bcc_state_t STATE_RESET = '{
    prev_level: 1'b1,
    edge_armed: 1'b1,
    db_run:     1'b0,
    db_rem:     '0,
    win_run:    1'b0,
    win_rem:    '0,
    pending:    1'b0
  };

endpackage

FILE: hdl/bcc_cfg.sv
`timescale 1ns / 1ps

module bcc_cfg import bcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_data,
  output bcc_cfg_t           cfg
);

  bcc_cfg_t cfg_r;
  bcc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS: cfg_nxt.debounce_ticks = cfg_data;
        CFG_WINDOW_TICKS:   cfg_nxt.window_ticks   = cfg_data;
        CFG_DOUBLE_ENABLE:  cfg_nxt.double_enable  = cfg_data[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RESET;
      cfg_r.window_ticks   <= WINDOW_RESET;
      cfg_r.double_enable  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/bcc_step.sv
`timescale 1ns / 1ps

module bcc_step import bcc_pkg::*; (
  input  bcc_state_t st,
  input  bcc_cfg_t   cfg,
  input  logic       pin_level,
  output bcc_state_t st_nxt,
  output logic       single_click,
  output logic       double_click
);

  always_comb begin
    st_nxt       = st;
    single_click = 1'b0;
    double_click = 1'b0;

    // window first
    if (st.win_run) begin
      if (st.win_rem <= CountW'(1)) begin
        single_click   = st.pending;
        st_nxt.win_run = 1'b0;
        st_nxt.win_rem = '0;
        st_nxt.pending = 1'b0;
      end else begin
        st_nxt.win_rem = st.win_rem - CountW'(1);
      end
    end

    // debounce expiry samples the pin
    if (st.db_run) begin
      if (st.db_rem <= CountW'(1)) begin
        st_nxt.db_run     = 1'b0;
        st_nxt.db_rem     = '0;
        st_nxt.edge_armed = 1'b1;
        if (!pin_level) begin
          if (st_nxt.pending) begin
            double_click   = 1'b1;
            st_nxt.pending = 1'b0;
            st_nxt.win_run = 1'b0;
            st_nxt.win_rem = '0;
          end else if (!cfg.double_enable) begin
            single_click = 1'b1;
          end else begin
            st_nxt.pending = 1'b1;
            st_nxt.win_run = 1'b1;
            st_nxt.win_rem = cfg.window_ticks;
          end
        end
      end else begin
        st_nxt.db_rem = st.db_rem - CountW'(1);
      end
    end

    if (st.edge_armed && st.prev_level && !pin_level) begin
      st_nxt.edge_armed = 1'b0;
      st_nxt.db_run     = 1'b1;
      st_nxt.db_rem     = cfg.debounce_ticks;
    end

    st_nxt.prev_level = pin_level;
  end

endmodule

FILE: hdl/button_click_classifier.sv
`timescale 1ns / 1ps

// Debounces an active-low button sampled once per transaction and reports
// single and double clicks. One input transaction is taken every clock cycle
// while the output side keeps up; its result (single_click, double_click)
// appears in the output register on the next cycle. The state update for one
// tick is a single pass through the step logic, so the rate is one tick per
// cycle; a stalled output holds one result and input waits only while that
// result is not taken. Configuration writes are taken in any cycle and apply
// to countdowns started afterward.
module button_click_classifier import bcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_pin_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_single_click,
  output logic               out_double_click,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_data
);

  bcc_cfg_t   cfg;
  bcc_state_t st_r;
  bcc_state_t st_nxt;
  logic       single_nxt;
  logic       double_nxt;
  logic       out_valid_r;
  logic       single_r;
  logic       double_r;
  logic       in_accept;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_step u_step (
    .st           (st_r),
    .cfg          (cfg),
    .pin_level    (in_pin_level),
    .st_nxt       (st_nxt),
    .single_click (single_nxt),
    .double_click (double_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_single_click = single_r;
  assign out_double_click = double_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      st_r        <= st_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      single_r <= single_nxt;
      double_r <= double_nxt;
    end
  end

endmodule
